### hdl/ljab_pkg.sv
// Shared types, constants and saturating helpers for the LJ pair energy block.
// No dependencies; every other file imports this package.
package ljab_pkg;

  localparam int COORD_FRAC_BITS = 20;
  localparam int INV_FRAC        = 56;
  localparam int R2_SHIFT        = 2 * COORD_FRAC_BITS - 40;
  localparam int R2_RSH          = (R2_SHIFT >= 0) ? R2_SHIFT : 0;
  localparam int R2_LSH          = (R2_SHIFT < 0) ? -R2_SHIFT : 0;
  localparam bit R2_LEFT         = (R2_SHIFT < 0);

  localparam logic [63:0] SMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN       = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INV_FLOOR  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] CUTOFF_RST = 64'h0000_4000_0000_0000;

  localparam logic REG_CUTOFF = 1'b0;
  localparam logic REG_GRAD   = 1'b1;

  typedef struct packed {
    logic [63:0] cutoff_squared;
    logic        gradient_enable;
  } cfg_t;

  typedef struct packed {
    logic [2:0][32:0] ad;
    logic [2:0]       neg;
    logic [63:0]      r2;
    logic             in_range;
    logic             r2_sat;
    logic [31:0]      tra;
    logic [31:0]      pra;
    logic [31:0]      trb;
    logic [31:0]      prb;
    logic             first_pair;
  } pair_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } qctl_t;

  // {sat, value}
  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = {1'b1, s[64] ? SMIN : SMAX};
    end else begin
      sat_add = {1'b0, s[63:0]};
    end
  endfunction

  function automatic logic [64:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    logic        s;
    s = (mag > SMAX);
    m = s ? SMAX : mag;
    sat_mag = {s, neg ? (~m + 64'd1) : m};
  endfunction

endpackage

### hdl/ljab_front.sv
// Front end: accepts pair beats, forms displacements and squared distance, classifies range.
// Depends on ljab_pkg; feeds ljab_queue.
module ljab_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         template_x,
  input  logic [31:0]         template_y,
  input  logic [31:0]         template_z,
  input  logic [31:0]         pore_x,
  input  logic [31:0]         pore_y,
  input  logic [31:0]         pore_z,
  input  logic [31:0]         template_root_a,
  input  logic [31:0]         pore_root_a,
  input  logic [31:0]         template_root_b,
  input  logic [31:0]         pore_root_b,
  input  logic                first_pair,
  input  ljab_pkg::cfg_t      cfg,
  input  logic                q_full,
  output logic                q_push,
  output ljab_pkg::pair_t     q_data
);
  import ljab_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SQ   = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t     state, state_next;
  pair_t       ent;
  logic [1:0]  step;
  logic [67:0] acc;
  logic [2:0][32:0] d;
  logic [65:0] sq;
  logic [67:0] r_sh;
  logic [95:0] l_sh;
  logic [63:0] r2;
  logic        r2_sat;

  assign in_ready = (state == F_IDLE);

  always_comb begin
    d[0] = {template_x[31], template_x} - {pore_x[31], pore_x};
    d[1] = {template_y[31], template_y} - {pore_y[31], pore_y};
    d[2] = {template_z[31], template_z} - {pore_z[31], pore_z};
  end

  assign sq   = ent.ad[step] * ent.ad[step];
  assign r_sh = acc >> R2_RSH;
  assign l_sh = {28'd0, acc} << R2_LSH;

  always_comb begin
    if (R2_LEFT) begin
      r2_sat = |l_sh[95:64];
      r2     = r2_sat ? ALL_ONES : l_sh[63:0];
    end else begin
      r2_sat = |r_sh[67:64];
      r2     = r2_sat ? ALL_ONES : r_sh[63:0];
    end
  end

  always_comb begin
    q_data          = ent;
    q_data.r2       = r2;
    q_data.r2_sat   = r2_sat;
    q_data.in_range = (r2 <= cfg.cutoff_squared);
  end

  assign q_push = (state == F_PUSH) && !q_full;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid) state_next = F_SQ;
      F_SQ:   if (step == 2'd2) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        ent.neg[i] <= d[i][32];
        ent.ad[i]  <= d[i][32] ? (~d[i] + 33'd1) : d[i];
      end
      ent.tra        <= template_root_a;
      ent.pra        <= pore_root_a;
      ent.trb        <= template_root_b;
      ent.prb        <= pore_root_b;
      ent.first_pair <= first_pair;
      ent.r2         <= '0;
      ent.in_range   <= 1'b0;
      ent.r2_sat     <= 1'b0;
      acc            <= '0;
      step           <= 2'd0;
    end else if (state == F_SQ) begin
      acc  <= acc + {2'd0, sq};
      step <= step + 2'd1;
    end
  end

endmodule

### hdl/ljab_queue.sv
// Two-entry queue between front end and back end.
// Depends on ljab_pkg for the pair entry type.
module ljab_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            pop,
  input  ljab_pkg::pair_t wdata,
  output ljab_pkg::pair_t rdata,
  output logic            full,
  output logic            empty
);
  import ljab_pkg::*;

  pair_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hdl/ljab_back.sv
// Back end: reciprocal, shared multi-cycle multiplier, saturation and running totals.
// Depends on ljab_pkg; drains ljab_queue and drives the result beat.
module ljab_back (
  input  logic               clk,
  input  logic               rst,
  input  ljab_pkg::cfg_t     cfg,
  input  ljab_pkg::pair_t    head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               in_range,
  output logic signed [63:0] pair_energy,
  output logic signed [63:0] gradient_x,
  output logic signed [63:0] gradient_y,
  output logic signed [63:0] gradient_z,
  output logic signed [63:0] total_repulsion,
  output logic signed [63:0] total_dispersion,
  output logic signed [63:0] total_energy,
  output logic               saturated
);
  import ljab_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_DIV  = 6'b000010,
    B_MUL  = 6'b000100,
    B_WB   = 6'b001000,
    B_FIN1 = 6'b010000,
    B_FIN2 = 6'b100000
  } bstate_t;

  typedef enum logic [4:0] {
    OP_A    = 5'd0,
    OP_B    = 5'd1,
    OP_P2   = 5'd2,
    OP_P3   = 5'd3,
    OP_P6   = 5'd4,
    OP_REP  = 5'd5,
    OP_DISP = 5'd6,
    OP_P4   = 5'd7,
    OP_P7   = 5'd8,
    OP_KREP = 5'd9,
    OP_KDSP = 5'd10,
    OP_GR0  = 5'd11,
    OP_GD0  = 5'd12,
    OP_GR1  = 5'd13,
    OP_GD1  = 5'd14,
    OP_GR2  = 5'd15,
    OP_GD2  = 5'd16
  } op_t;

  bstate_t      state;
  op_t          op;
  pair_t        cur;
  logic [63:0]  inv, rem, quo, rem_next, quo_next;
  logic [4:0]   cnt;
  logic [1:0]   mstep;
  logic [127:0] acc;
  logic [63:0]  a, b, p2, p3, p6, p4, p7, repm, dispm, krep, kdisp;
  logic [2:0][63:0] grm, gdm;
  logic         sat;
  logic [63:0]  rep_sum, disp_sum, pair_r;
  logic [2:0][63:0] g_r;

  logic [63:0]  ma, mb;
  logic [31:0]  ma_h, mb_h;
  logic [63:0]  prod;
  logic [6:0]   psh;
  logic [63:0]  n56, nf;
  logic         s56, sf;
  logic [67:0]  x12, x6;
  logic         div_c;
  logic [63:0]  div_s;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    div_c    = 1'b0;
    div_s    = '0;
    for (int k = 0; k < 2; k++) begin
      div_c = rem_next[63];
      div_s = {rem_next[62:0], 1'b0};
      if (div_c || div_s >= cur.r2) begin
        rem_next = div_s - cur.r2;
        quo_next = {quo_next[62:0], 1'b1};
      end else begin
        rem_next = div_s;
        quo_next = {quo_next[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      OP_A:    begin ma = {32'd0, cur.tra}; mb = {32'd0, cur.pra}; end
      OP_B:    begin ma = {32'd0, cur.trb}; mb = {32'd0, cur.prb}; end
      OP_P2:   begin ma = inv;   mb = inv; end
      OP_P3:   begin ma = p2;    mb = inv; end
      OP_P6:   begin ma = p3;    mb = p3; end
      OP_REP:  begin ma = a;     mb = p6; end
      OP_DISP: begin ma = b;     mb = p3; end
      OP_P4:   begin ma = p2;    mb = p2; end
      OP_P7:   begin ma = p6;    mb = inv; end
      OP_KREP: begin ma = a;     mb = p7; end
      OP_KDSP: begin ma = b;     mb = p4; end
      OP_GR0:  begin ma = krep;  mb = {31'd0, cur.ad[0]}; end
      OP_GD0:  begin ma = kdisp; mb = {31'd0, cur.ad[0]}; end
      OP_GR1:  begin ma = krep;  mb = {31'd0, cur.ad[1]}; end
      OP_GD1:  begin ma = kdisp; mb = {31'd0, cur.ad[1]}; end
      OP_GR2:  begin ma = krep;  mb = {31'd0, cur.ad[2]}; end
      OP_GD2:  begin ma = kdisp; mb = {31'd0, cur.ad[2]}; end
      default: begin ma = '0;    mb = '0; end
    endcase
  end

  assign ma_h = mstep[1] ? ma[63:32] : ma[31:0];
  assign mb_h = mstep[0] ? mb[63:32] : mb[31:0];
  assign prod = ma_h * mb_h;
  assign psh  = {({1'b0, mstep[1]} + {1'b0, mstep[0]}), 5'd0};

  assign s56 = |acc[127:64+INV_FRAC];
  assign n56 = s56 ? ALL_ONES : acc[63+INV_FRAC:INV_FRAC];
  assign sf  = |acc[127:64+COORD_FRAC_BITS];
  assign nf  = sf ? ALL_ONES : acc[63+COORD_FRAC_BITS:COORD_FRAC_BITS];
  assign x12 = {4'd0, n56} * 68'd12;
  assign x6  = {4'd0, n56} * 68'd6;

  logic [64:0] rep_s, disp_s, rs, ds, tot;
  logic [2:0][64:0] grs, gds, gsum;
  logic [63:0] base_r, base_d;
  logic        gsat;

  always_comb begin
    rep_s  = sat_mag(repm, 1'b0);
    disp_s = sat_mag(dispm, 1'b0);
    base_r = cur.first_pair ? 64'd0 : rep_sum;
    base_d = cur.first_pair ? 64'd0 : disp_sum;
    rs     = sat_add(base_r, rep_s[63:0]);
    ds     = sat_add(base_d, ~disp_s[63:0] + 64'd1);
    gsat   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      grs[i] = sat_mag(grm[i], !cur.neg[i]);
      gds[i] = sat_mag(gdm[i], cur.neg[i]);
      if (cur.ad[i] == 33'd0) begin
        grs[i] = '0;
        gds[i] = '0;
      end
      gsum[i] = sat_add(grs[i][63:0], gds[i][63:0]);
      gsat    = gsat | grs[i][64] | gds[i][64] | gsum[i][64];
    end
    tot = sat_add(rep_sum, disp_sum);
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      rep_sum   <= '0;
      disp_sum  <= '0;
    end else begin
      if (out_valid && out_ready && state != B_FIN2) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            if (!head.in_range) state <= B_FIN1;
            else if (head.r2 <= INV_FLOOR) state <= B_MUL;
            else state <= B_DIV;
          end
        end
        B_DIV:  if (cnt == 5'd31) state <= B_MUL;
        B_MUL:  if (mstep == 2'd3) state <= B_WB;
        B_WB: begin
          if ((op == OP_DISP && !cfg.gradient_enable) || op == OP_GD2) state <= B_FIN1;
          else state <= B_MUL;
        end
        B_FIN1: begin
          state <= B_FIN2;
          if (cur.in_range) begin
            rep_sum  <= rs[63:0];
            disp_sum <= ds[63:0];
          end else begin
            rep_sum  <= base_r;
            disp_sum <= base_d;
          end
        end
        B_FIN2: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        cur   <= head;
        sat   <= head.r2_sat | (head.in_range && head.r2 <= INV_FLOOR);
        rem   <= INV_FLOOR;
        quo   <= '0;
        cnt   <= 5'd0;
        op    <= OP_A;
        mstep <= 2'd0;
        acc   <= '0;
        if (head.in_range && head.r2 <= INV_FLOOR) begin
          inv <= ALL_ONES;
        end
      end
      B_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) inv <= quo_next;
      end
      B_MUL: begin
        acc   <= acc + ({64'd0, prod} << psh);
        mstep <= mstep + 2'd1;
      end
      B_WB: begin
        acc   <= '0;
        mstep <= 2'd0;
        op    <= op_t'(op + 5'd1);
        case (op)
          OP_A:    a <= acc[63:0];
          OP_B:    b <= acc[63:0];
          OP_P2:   begin p2 <= n56; sat <= sat | s56; end
          OP_P3:   begin p3 <= n56; sat <= sat | s56; end
          OP_P6:   begin p6 <= n56; sat <= sat | s56; end
          OP_REP:  begin repm <= n56; sat <= sat | s56; end
          OP_DISP: begin dispm <= n56; sat <= sat | s56; end
          OP_P4:   begin p4 <= n56; sat <= sat | s56; end
          OP_P7:   begin p7 <= n56; sat <= sat | s56; end
          OP_KREP: begin
            krep <= (|x12[67:64]) ? ALL_ONES : x12[63:0];
            sat  <= sat | s56 | (|x12[67:64]);
          end
          OP_KDSP: begin
            kdisp <= (|x6[67:64]) ? ALL_ONES : x6[63:0];
            sat   <= sat | s56 | (|x6[67:64]);
          end
          OP_GR0:  begin grm[0] <= nf; sat <= sat | sf; end
          OP_GD0:  begin gdm[0] <= nf; sat <= sat | sf; end
          OP_GR1:  begin grm[1] <= nf; sat <= sat | sf; end
          OP_GD1:  begin gdm[1] <= nf; sat <= sat | sf; end
          OP_GR2:  begin grm[2] <= nf; sat <= sat | sf; end
          OP_GD2:  begin gdm[2] <= nf; sat <= sat | sf; end
          default: a <= a;
        endcase
      end
      B_FIN1: begin
        if (cur.in_range) begin
          pair_r <= rep_s[63:0] - disp_s[63:0];
          sat    <= sat | rep_s[64] | disp_s[64] | rs[64] | ds[64]
                    | (cfg.gradient_enable & gsat);
          for (int i = 0; i < 3; i++) begin
            g_r[i] <= cfg.gradient_enable ? gsum[i][63:0] : 64'd0;
          end
        end else begin
          pair_r <= '0;
          g_r    <= '0;
        end
      end
      B_FIN2: begin
        if (!out_valid || out_ready) begin
          in_range         <= cur.in_range;
          pair_energy      <= pair_r;
          gradient_x       <= g_r[0];
          gradient_y       <= g_r[1];
          gradient_z       <= g_r[2];
          total_repulsion  <= rep_sum;
          total_dispersion <= disp_sum;
          total_energy     <= tot[63:0];
          saturated        <= sat | tot[64];
        end
      end
      default: acc <= acc;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> pair_energy == 64'd0 && gradient_x == 64'd0
      && gradient_y == 64'd0 && gradient_z == 64'd0)
    else $error("out-of-range beat carries nonzero terms");
  a_grad_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cfg.gradient_enable |-> gradient_x == 64'd0
      && gradient_y == 64'd0 && gradient_z == 64'd0)
    else $error("gradient nonzero while disabled");
  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && !saturated |-> total_energy == total_repulsion + total_dispersion)
    else $error("total energy mismatch without saturation");
`endif

endmodule

### hdl/lj_ab_pair_energy_gradient.sv
// Top level of the LJ 12-6 pair energy and gradient block: APB registers and wiring.
// Depends on ljab_pkg, ljab_front, ljab_queue and ljab_back.
//
//   channel  | handshake            | beat
//   ---------+----------------------+------------------------------------------
//   apb      | psel/penable/pwrite  | paddr, pwdata -> cutoff or gradient enable
//   in       | in_valid/in_ready    | one template/pore atom pair
//   out      | out_valid/out_ready  | pair energy, gradient, running totals
//
// Front does the three squares in turn on one 33x33 multiplier, taking no new pair
// until the last is pushed. The reciprocal comes two quotient bits per cycle, then
// each 64x64 product from partials on one 32x32 multiplier: 7 products, 17 with
// gradients. Out-of-range pairs skip all of this; tiny ones skip the divide.
// Reset is synchronous and clears totals, queue and handshakes; no clearing pass.
// A stalled output holds in its register; the front accepts until the queue fills.
module lj_ab_pair_energy_gradient (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] template_x,
  input  logic signed [31:0] template_y,
  input  logic signed [31:0] template_z,
  input  logic signed [31:0] pore_x,
  input  logic signed [31:0] pore_y,
  input  logic signed [31:0] pore_z,
  input  logic [31:0]        template_root_a,
  input  logic [31:0]        pore_root_a,
  input  logic [31:0]        template_root_b,
  input  logic [31:0]        pore_root_b,
  input  logic               first_pair,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               in_range,
  output logic signed [63:0] pair_energy,
  output logic signed [63:0] gradient_x,
  output logic signed [63:0] gradient_y,
  output logic signed [63:0] gradient_z,
  output logic signed [63:0] total_repulsion,
  output logic signed [63:0] total_dispersion,
  output logic signed [63:0] total_energy,
  output logic               saturated
);
  import ljab_pkg::*;

  cfg_t  cfg;
  qctl_t qc;
  pair_t q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_CUTOFF) ? cfg.cutoff_squared
                                           : {63'd0, cfg.gradient_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_squared  <= CUTOFF_RST;
      cfg.gradient_enable <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_CUTOFF: cfg.cutoff_squared  <= pwdata;
        REG_GRAD:   cfg.gradient_enable <= pwdata[0];
        default:    cfg <= cfg;
      endcase
    end
  end

  ljab_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .template_x(template_x), .template_y(template_y), .template_z(template_z),
    .pore_x(pore_x), .pore_y(pore_y), .pore_z(pore_z),
    .template_root_a, .pore_root_a, .template_root_b, .pore_root_b, .first_pair,
    .cfg, .q_full(qc.full), .q_push(qc.push), .q_data(q_wdata)
  );

  ljab_queue u_queue (
    .clk, .rst, .push(qc.push), .pop(qc.pop), .wdata(q_wdata), .rdata(q_rdata),
    .full(qc.full), .empty(qc.empty)
  );

  ljab_back u_back (
    .clk, .rst, .cfg, .head(q_rdata), .q_empty(qc.empty), .q_pop(qc.pop),
    .out_valid, .out_ready, .in_range, .pair_energy, .gradient_x, .gradient_y,
    .gradient_z, .total_repulsion, .total_dispersion, .total_energy, .saturated
  );

endmodule

### verif/tb.sv
// Testbench for lj_ab_pair_energy_gradient: random and directed atom pairs,
// APB register writes between phases, scoreboard class predicting each beat.
// Depends on ljab_pkg and the block RTL.
module tb;
  import ljab_pkg::*;

  localparam logic [3:0] ADDR_CUTOFF = 4'd0;
  localparam logic [3:0] ADDR_GRAD   = 4'd8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] tx, ty, tz, px, py, pz;
    logic [31:0]        ta, pa, tb_, pb;
    logic               fp;
  } pair_in_t;

  typedef struct {
    logic        in_range;
    logic [63:0] pair_energy, gx, gy, gz, trep, tdisp, tsum;
    logic        saturated;
  } lj_result_t;

  class lj_scoreboard;
    logic [63:0]  cutoff_sq = CUTOFF_RST;
    logic         grad_en = 1'b1;
    logic signed [63:0] rep_sum = 0, disp_sum = 0;
    lj_result_t   pending[$];
    int           errors = 0;

    function automatic logic [63:0] shr(logic [127:0] p, int s, ref bit sat);
      logic [127:0] q;
      q = p >> s;
      if (q[127:64] != 0) begin
        sat = 1;
        return ALL_ONES;
      end
      return q[63:0];
    endfunction

    function automatic logic [63:0] mshift(logic [63:0] a, logic [63:0] b, int s, ref bit sat);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return shr(p, s, sat);
    endfunction

    function automatic logic [63:0] smag(logic [63:0] m, bit neg, ref bit sat);
      if (m > SMAX) begin
        sat = 1;
        m = SMAX;
      end
      return neg ? -m : m;
    endfunction

    function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b,
                                                 ref bit sat);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
        sat = 1;
        return s[64] ? SMIN : SMAX;
      end
      return s[63:0];
    endfunction

    function automatic logic [63:0] mul_k(logic [63:0] x, int k, ref bit sat);
      logic [127:0] p;
      p = {64'd0, x} * k;
      if (p[127:64] != 0) begin
        sat = 1;
        return ALL_ONES;
      end
      return p[63:0];
    endfunction

    function void note_pair(pair_in_t p);
      lj_result_t r;
      bit sat;
      logic signed [33:0] d[3];
      logic [32:0] ad[3];
      logic [127:0] sq;
      logic [63:0] r2, a, b, inv, p2, p3, p4, p6, p7, krep, kdisp, rm, dm;
      logic signed [63:0] rep, disp, gr, gd;
      logic [127:0] num;
      sat = 0;
      d[0] = p.tx - p.px;
      d[1] = p.ty - p.py;
      d[2] = p.tz - p.pz;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        ad[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
        sq += {95'd0, ad[i]} * {95'd0, ad[i]};
      end
      if (R2_LEFT) begin
        if (sq >> (64 - R2_LSH) != 0) begin
          sat = 1;
          r2 = ALL_ONES;
        end else r2 = sq[63:0] << R2_LSH;
      end else r2 = shr(sq, R2_RSH, sat);
      r = '{default: 0};
      r.in_range = r2 <= cutoff_sq;
      if (p.fp) begin
        rep_sum = 0;
        disp_sum = 0;
      end
      if (r.in_range) begin
        a = {32'd0, p.ta} * {32'd0, p.pa};
        b = {32'd0, p.tb_} * {32'd0, p.pb};
        if (r2 <= INV_FLOOR) begin
          inv = ALL_ONES;
          sat = 1;
        end else begin
          num = 128'd1 << 96;
          inv = 64'(num / r2);
        end
        p2 = mshift(inv, inv, INV_FRAC, sat);
        p3 = mshift(p2, inv, INV_FRAC, sat);
        p6 = mshift(p3, p3, INV_FRAC, sat);
        rep = smag(mshift(a, p6, INV_FRAC, sat), 0, sat);
        disp = smag(mshift(b, p3, INV_FRAC, sat), 0, sat);
        r.pair_energy = rep - disp;
        if (grad_en) begin
          p4 = mshift(p2, p2, INV_FRAC, sat);
          p7 = mshift(p6, inv, INV_FRAC, sat);
          krep = mul_k(mshift(a, p7, INV_FRAC, sat), 12, sat);
          kdisp = mul_k(mshift(b, p4, INV_FRAC, sat), 6, sat);
          for (int i = 0; i < 3; i++) begin
            rm = mshift(krep, {31'd0, ad[i]}, COORD_FRAC_BITS, sat);
            gr = smag(rm, !(d[i] < 0), sat);
            dm = mshift(kdisp, {31'd0, ad[i]}, COORD_FRAC_BITS, sat);
            gd = smag(dm, d[i] < 0, sat);
            if (ad[i] == 0) begin
              gr = 0;
              gd = 0;
            end
            case (i)
              0: r.gx = sadd(gr, gd, sat);
              1: r.gy = sadd(gr, gd, sat);
              default: r.gz = sadd(gr, gd, sat);
            endcase
          end
        end
        rep_sum = sadd(rep_sum, rep, sat);
        disp_sum = sadd(disp_sum, -disp, sat);
      end
      r.tsum = sadd(rep_sum, disp_sum, sat);
      r.trep = rep_sum;
      r.tdisp = disp_sum;
      r.saturated = sat;
      pending.push_back(r);
    endfunction

    function void cmp(string n, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t mismatch %s expected %h actual %h", $time, n, e, a);
      end
    endfunction

    function void check_result(lj_result_t a);
      lj_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat", $time);
        return;
      end
      e = pending.pop_front();
      cmp("in_range", e.in_range, a.in_range);
      cmp("pair_energy", e.pair_energy, a.pair_energy);
      cmp("gradient_x", e.gx, a.gx);
      cmp("gradient_y", e.gy, a.gy);
      cmp("gradient_z", e.gz, a.gz);
      cmp("total_repulsion", e.trep, a.trep);
      cmp("total_dispersion", e.tdisp, a.tdisp);
      cmp("total_energy", e.tsum, a.tsum);
      cmp("saturated", e.saturated, a.saturated);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [63:0] pwdata = 0, prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic signed [31:0] template_x = 0, template_y = 0, template_z = 0;
  logic signed [31:0] pore_x = 0, pore_y = 0, pore_z = 0;
  logic [31:0] template_root_a = 0, pore_root_a = 0, template_root_b = 0, pore_root_b = 0;
  logic first_pair = 0;
  logic out_valid, out_ready = 0;
  logic in_range, saturated;
  logic signed [63:0] pair_energy, gradient_x, gradient_y, gradient_z;
  logic signed [63:0] total_repulsion, total_dispersion, total_energy;

  lj_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0;
  bit sink_on = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  lj_ab_pair_energy_gradient i_dut (.*);

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    lj_result_t a;
    if (!rst && out_valid && out_ready) begin
      a.in_range = in_range;
      a.pair_energy = pair_energy;
      a.gx = gradient_x;
      a.gy = gradient_y;
      a.gz = gradient_z;
      a.trep = total_repulsion;
      a.tdisp = total_dispersion;
      a.tsum = total_energy;
      a.saturated = saturated;
      sb.check_result(a);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int g;
    @(negedge clk);
    forever begin
      if (!sink_on || hold_off) out_ready <= 0;
      else begin
        g = gap_len();
        if (g == 0 || $urandom_range(0, 3) == 0) out_ready <= 1;
        else begin
          out_ready <= 0;
          repeat (g) @(negedge clk);
          out_ready <= 1;
        end
      end
      @(negedge clk);
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [63:0] data);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == ADDR_CUTOFF) sb.cutoff_sq = data;
    else sb.grad_en = data[0];
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic send_pair(pair_in_t p, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    template_x <= p.tx;
    template_y <= p.ty;
    template_z <= p.tz;
    pore_x <= p.px;
    pore_y <= p.py;
    pore_z <= p.pz;
    template_root_a <= p.ta;
    pore_root_a <= p.pa;
    template_root_b <= p.tb_;
    pore_root_b <= p.pb;
    first_pair <= p.fp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_root();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000);
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0000_8000, 32'h0010_0000);
    endcase
  endfunction

  function automatic pair_in_t rnd_pair();
    pair_in_t p;
    int spread;
    p.tx = $urandom();
    p.ty = $urandom();
    p.tz = $urandom();
    case ($urandom_range(0, 9))
      0, 1: begin
        p.px = $urandom();
        p.py = $urandom();
        p.pz = $urandom();
      end
      2: begin
        p.px = p.tx;
        p.py = p.ty;
        p.pz = p.tz;
      end
      default: begin
        spread = 1 << $urandom_range(14, 23);
        p.px = p.tx + $signed($urandom_range(0, 2 * spread)) - spread;
        p.py = p.ty + $signed($urandom_range(0, 2 * spread)) - spread;
        p.pz = p.tz + $signed($urandom_range(0, 2 * spread)) - spread;
      end
    endcase
    p.ta = rnd_root();
    p.pa = rnd_root();
    p.tb_ = rnd_root();
    p.pb = rnd_root();
    p.fp = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  function automatic pair_in_t mk(logic signed [31:0] dx, logic signed [31:0] tx,
                                  logic [31:0] root, bit fp);
    pair_in_t p;
    p.tx = tx;
    p.ty = 0;
    p.tz = 0;
    p.px = tx - dx;
    p.py = 0;
    p.pz = 0;
    p.ta = root;
    p.pa = root;
    p.tb_ = root;
    p.pb = root;
    p.fp = fp;
    return p;
  endfunction

  initial begin
    pair_in_t p;
    logic [63:0] cut[4];
    cut = '{64'd0, CUTOFF_RST, 64'h0001_0000_0000_0000, ALL_ONES};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    sink_on = 1;
    reg_write(ADDR_CUTOFF, CUTOFF_RST);
    reg_write(ADDR_GRAD, 64'd1);

    send_pair(mk(32'sd0, 32'sd0, 32'h0001_0000, 1), 0);
    send_pair(mk(32'sd1, 32'sd5, 32'h0001_0000, 0), 0);
    send_pair(mk(32'sd1 <<< 20, 32'sd0, 32'h0001_0000, 0), 0);
    send_pair(mk(-(32'sd1 <<< 20), 32'sd0, 32'h0002_0000, 0), 0);
    send_pair(mk(32'sd3 <<< 20, 32'sd100, 32'hFFFF_FFFF, 0), 0);
    send_pair(mk(32'sd7 <<< 20, 32'sd0, 32'h0001_0000, 0), 0);
    send_pair(mk(32'sd9 <<< 20, 32'sd0, 32'h0001_0000, 0), 0);
    send_pair(mk(32'sd1 <<< 16, 32'sd0, 32'hFFFF_FFFF, 0), 0);
    send_pair(mk(32'sd1 <<< 8, 32'sd0, 32'h0000_0000, 1), 0);
    p = mk(32'sd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    p.px = 32'h8000_0000;
    p.py = 32'h7FFF_FFFF;
    p.ty = 32'h8000_0000;
    send_pair(p, 0);
    p = mk(32'sd1 <<< 20, 32'sd0, 32'h0001_0000, 0);
    p.ty = 32'sd1 <<< 19;
    p.tz = -(32'sd1 <<< 19);
    p.pa = 32'h0;
    send_pair(p, 0);
    drain();
    reg_write(ADDR_GRAD, 64'd0);
    send_pair(mk(32'sd1 <<< 20, 32'sd0, 32'h0003_0000, 1), 0);
    send_pair(mk(32'sd0, 32'sd0, 32'h0001_0000, 0), 0);
    drain();

    hold_off = 1;
    fork
      begin
        repeat (800) @(negedge clk);
        hold_off = 0;
      end
    join_none
    for (int i = 0; i < 12; i++) send_pair(rnd_pair(), 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      reg_write(ADDR_CUTOFF, ph < 4 ? cut[ph] : {$urandom(), $urandom()} >> $urandom_range(0, 40));
      reg_write(ADDR_GRAD, 64'(ph % 2));
      for (int i = 0; i < 185; i++) send_pair(rnd_pair(), 1);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### lj_ab_pair_energy_gradient.f
hdl/ljab_pkg.sv
hdl/ljab_front.sv
hdl/ljab_queue.sv
hdl/ljab_back.sv
hdl/lj_ab_pair_energy_gradient.sv
verif/tb.sv
